FILE: hw/rtl/tkl_pkg.sv
package tkl_pkg;

    localparam int DEFAULT_MAX_ENTRIES  = 16;
    localparam int DEFAULT_PAYLOAD_BITS = 64;
    localparam int DEFAULT_SCORE_BITS   = 32;
    localparam int DEFAULT_CAPACITY     = 10;

    localparam int SCORE_FIELD_W   = 32;
    localparam int PAYLOAD_FIELD_W = 64;
    localparam int CAP_W           = 5;
    localparam int OUTCOME_W       = 2;
    localparam int RANK_W          = 4;
    localparam int TOTAL_W         = 5;

    localparam int IN_TDATA_W  = 96;
    localparam int RESULT_W    = OUTCOME_W + RANK_W + 1 + TOTAL_W;
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [OUTCOME_W-1:0] OUTCOME_INSERTED   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_NOT_BETTER = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_DUPLICATE  = 2'd2;

    // first member lands in the top bits
    typedef struct packed {
        logic [TOTAL_W-1:0]   entry_total;
        logic                 evicted;
        logic [RANK_W-1:0]    rank;
        logic [OUTCOME_W-1:0] outcome;
    } result_t;

    typedef struct packed {
        logic valid;
        logic wr_en;
    } cell_ctl_t;

    typedef struct packed {
        logic ge;
        logic dup;
    } cell_flags_t;

    function automatic int eff_capacity(logic [CAP_W-1:0] cap, int max_entries);
        int c;
        c = (cap == '0) ? DEFAULT_CAPACITY : int'(cap);
        if (c > max_entries)
        begin
            c = max_entries;
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/tkl_cell.sv
module tkl_cell #(
    parameter int SCORE_BITS   = tkl_pkg::DEFAULT_SCORE_BITS,
    parameter int PAYLOAD_BITS = tkl_pkg::DEFAULT_PAYLOAD_BITS
) (
    input  logic                    clk,
    input  tkl_pkg::cell_ctl_t      ctl,
    input  logic [SCORE_BITS-1:0]   cand_key,
    input  logic [PAYLOAD_BITS-1:0] cand_payload,
    input  logic                    left_ge,
    input  logic [SCORE_BITS-1:0]   left_key,
    input  logic [PAYLOAD_BITS-1:0] left_payload,
    output tkl_pkg::cell_flags_t    flags,
    output logic [SCORE_BITS-1:0]   key,
    output logic [PAYLOAD_BITS-1:0] payload
);
    import tkl_pkg::*;

    logic [SCORE_BITS-1:0]   key_reg;
    logic [SCORE_BITS-1:0]   key_next;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [PAYLOAD_BITS-1:0] payload_next;

    always_comb
    begin
        flags.ge  = ctl.valid && (key_reg >= cand_key);
        flags.dup = ctl.valid && (key_reg == cand_key) && (payload_reg == cand_payload);
    end

    // keep above the insert point, take the candidate at it, shift below it
    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (ctl.wr_en && !flags.ge)
        begin
            if (left_ge)
            begin
                key_next     = cand_key;
                payload_next = cand_payload;
            end
            else
            begin
                key_next     = left_key;
                payload_next = left_payload;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign key     = key_reg;
    assign payload = payload_reg;

endmodule

FILE: hw/rtl/top_k_ledger_with_dedup.sv
// Sorted top-k ledger with duplicate suppression. One candidate beat is taken per clock
// while s_tready is high; every cell compares its entry with the broadcast candidate and,
// on an insert, the entries below the insert point shift in the same cycle. Each result
// is registered into a two-beat output buffer; s_tready drops only when two are waiting.
// Capacity writes (0 means ten, clamped to MAX_ENTRIES) trim the held count at once.
// Entries come up undefined after reset; no clearing pass is needed.
module top_k_ledger_with_dedup #(
    parameter int MAX_ENTRIES  = tkl_pkg::DEFAULT_MAX_ENTRIES,
    parameter int PAYLOAD_BITS = tkl_pkg::DEFAULT_PAYLOAD_BITS,
    parameter int SCORE_BITS   = tkl_pkg::DEFAULT_SCORE_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [tkl_pkg::CAP_W-1:0]        cfg_wr_data,  // capacity
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tkl_pkg::IN_TDATA_W-1:0]   s_tdata,      // score[31:0], payload[95:32]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tkl_pkg::OUT_TDATA_W-1:0]  m_tdata       // outcome, rank, evicted,
                                                           // entry_total, zero pad
);
    import tkl_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic                    s_accept;
    logic                    m_pop;
    logic [SCORE_BITS-1:0]   score_sized;
    logic [SCORE_BITS-1:0]   cand_key;
    logic [PAYLOAD_BITS-1:0] cand_payload;

    logic [CNT_W-1:0] held_reg;
    logic [CNT_W-1:0] held_next;
    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] cap_next;

    cell_ctl_t   ctl       [MAX_ENTRIES];
    cell_flags_t flags     [MAX_ENTRIES];
    logic [SCORE_BITS-1:0]   cell_key     [MAX_ENTRIES];
    logic [PAYLOAD_BITS-1:0] cell_payload [MAX_ENTRIES];

    logic             any_dup;
    logic             any_ins;
    logic [CNT_W-1:0] pos;
    logic             full;
    logic             insert;
    result_t          res;

    result_t head_reg;
    result_t skid_reg;
    logic    head_valid_reg;
    logic    skid_valid_reg;

    assign s_accept = s_tvalid && s_tready;
    assign m_pop    = m_tvalid && m_tready;
    assign s_tready = !skid_valid_reg;

    assign score_sized  = SCORE_BITS'($signed(s_tdata[SCORE_FIELD_W-1:0]));
    assign cand_key     = {~score_sized[SCORE_BITS-1], score_sized[SCORE_BITS-2:0]};
    assign cand_payload = PAYLOAD_BITS'(s_tdata[SCORE_FIELD_W +: PAYLOAD_FIELD_W]);

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++)
        begin : g_cell
            logic                    l_ge;
            logic [SCORE_BITS-1:0]   l_key;
            logic [PAYLOAD_BITS-1:0] l_payload;

            if (g == 0)
            begin : g_first
                assign l_ge      = 1'b1;
                assign l_key     = cand_key;
                assign l_payload = cand_payload;
            end
            else
            begin : g_rest
                assign l_ge      = flags[g-1].ge;
                assign l_key     = cell_key[g-1];
                assign l_payload = cell_payload[g-1];
            end

            assign ctl[g].valid = held_reg > CNT_W'(g);
            assign ctl[g].wr_en = insert;

            tkl_cell #(
                .SCORE_BITS   (SCORE_BITS),
                .PAYLOAD_BITS (PAYLOAD_BITS)
            ) u_cell (
                .clk          (clk),
                .ctl          (ctl[g]),
                .cand_key     (cand_key),
                .cand_payload (cand_payload),
                .left_ge      (l_ge),
                .left_key     (l_key),
                .left_payload (l_payload),
                .flags        (flags[g]),
                .key          (cell_key[g]),
                .payload      (cell_payload[g])
            );
        end
    endgenerate

    always_comb
    begin
        any_dup = 1'b0;
        any_ins = 1'b0;
        pos     = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            any_dup = any_dup | flags[i].dup;
            if (!flags[i].ge && ((i == 0) || flags[(i == 0) ? 0 : i - 1].ge))
            begin
                any_ins = 1'b1;
                pos     = pos | CNT_W'(i);
            end
        end
        if (!any_ins)
        begin
            pos = CNT_W'(MAX_ENTRIES);
        end
    end

    always_comb
    begin
        full = held_reg >= cap_reg;
        res  = '0;
        if (full && (pos == held_reg))
        begin
            res.outcome = OUTCOME_NOT_BETTER;
        end
        else if (any_dup)
        begin
            res.outcome = OUTCOME_DUPLICATE;
        end
        else
        begin
            res.outcome = OUTCOME_INSERTED;
            res.rank    = RANK_W'(pos);
            res.evicted = full;
        end
        insert = s_accept && (res.outcome == OUTCOME_INSERTED);
        held_next = held_reg;
        if (insert && !full)
        begin
            held_next = held_reg + CNT_W'(1);
        end
        res.entry_total = TOTAL_W'(held_next);
    end

    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_wr_en)
        begin
            cap_next = CNT_W'(eff_capacity(cfg_wr_data, MAX_ENTRIES));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CNT_W'(eff_capacity(CAP_W'(DEFAULT_CAPACITY), MAX_ENTRIES));
            held_reg <= '0;
        end
        else
        begin
            cap_reg <= cap_next;
            if (cfg_wr_en)
            begin
                held_reg <= (held_reg > cap_next) ? cap_next : held_reg;
            end
            else
            begin
                held_reg <= held_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_pop)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= s_accept;
                end
                else
                begin
                    head_valid_reg <= s_accept;
                end
            end
            else if (s_accept)
            begin
                if (head_valid_reg)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    head_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_pop)
        begin
            if (skid_valid_reg)
            begin
                head_reg <= skid_reg;
                if (s_accept)
                begin
                    skid_reg <= res;
                end
            end
            else if (s_accept)
            begin
                head_reg <= res;
            end
        end
        else if (s_accept)
        begin
            if (head_valid_reg)
            begin
                skid_reg <= res;
            end
            else
            begin
                head_reg <= res;
            end
        end
    end

    assign m_tvalid = head_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(head_reg);

endmodule

FILE: hw/rtl/tkl_checker.sv
module tkl_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tkl_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import tkl_pkg::*;

    result_t r;
    assign r = m_tdata[RESULT_W-1:0];

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> m_tvalid)
        else $error("accepted beat produced no result");

    a_reject_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (r.outcome != OUTCOME_INSERTED) |-> (r.rank == '0) && !r.evicted)
        else $error("rejected beat carries rank or eviction");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && r.evicted |-> (r.outcome == OUTCOME_INSERTED) && (r.entry_total != '0))
        else $error("eviction without insert");

    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (r.outcome == OUTCOME_INSERTED) || (r.outcome == OUTCOME_NOT_BETTER)
                     || (r.outcome == OUTCOME_DUPLICATE))
        else $error("bad outcome code");

endmodule

bind top_k_ledger_with_dedup tkl_checker u_tkl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
